// ----- hdl/rsc_pkg.sv -----
`timescale 1ns / 1ps

package rsc_pkg;

  // Item kinds carried on s_tuser
  localparam logic [1:0] KIND_LOAD     = 2'd0;
  localparam logic [1:0] KIND_ENCIPHER = 2'd1;
  localparam logic [1:0] KIND_RESTART  = 2'd2;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned BYTE_W      = 8;

  // One item as it travels along the rotor chain
  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic [1:0]        table_select;
    logic [BYTE_W-1:0] entry_index;
    logic [BYTE_W-1:0] data;   // plain byte, then running cipher value
    logic              carry;  // counter carry into this rotor
  } item_t;

endpackage

// ----- hdl/rotating_sbox_cascade_cipher.sv -----
`timescale 1ns / 1ps

// Byte cipher built from STAGES rotating substitution tables in a chain, one
// table per cell. While s_tready is high an item may enter: a load (s_tuser = 0)
// writes one table entry, an encipher item (s_tuser = 1) passes its byte through
// all tables and gives one byte on m_tdata, a restart (s_tuser = 2) clears the
// rotation counter; kind 3 is dropped. Sustained rate is one item per clock
// while the output skid entry is empty, set by the single table read each cell
// makes per cycle; a full skid entry stalls the whole chain. Each cell keeps
// its own base-256 digit of the counter and the carry rides with the item, so
// items overlap freely. Table contents are undefined until loaded. A two-entry
// output buffer keeps s_tready high while one result waits.
module rotating_sbox_cascade_cipher import rsc_pkg::*; #(
  parameter int unsigned STAGES = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // table_select[1:0], entry_index[9:2], data_byte[17:10]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // cipher_byte[7:0]
);

  item_t             chain [STAGES+1];
  logic              adv;
  logic              take;
  logic              out_valid;
  logic [BYTE_W-1:0] out_data;
  logic              skid_valid;
  logic [BYTE_W-1:0] skid_data;

  assign adv      = !skid_valid;
  assign s_tready = adv;

  // Head of the chain
  always_comb begin
    chain[0].valid        = s_tvalid && adv;
    chain[0].kind         = s_tuser;
    chain[0].table_select = s_tdata[1:0];
    chain[0].entry_index  = s_tdata[9:2];
    chain[0].data         = s_tdata[17:10];
    chain[0].carry        = 1'b1;
  end

  // Rotor cells
  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    rsc_rotor_cell #(
      .INDEX(g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_item  (chain[g]),
      .out_item (chain[g+1])
    );
  end

  assign take = adv && chain[STAGES].valid && (chain[STAGES].kind == KIND_ENCIPHER);

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= take;
        out_data  <= chain[STAGES].data;
      end
    end else if (take) begin
      skid_valid <= 1'b1;
      skid_data  <= chain[STAGES].data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// ----- hdl/rsc_rotor_cell.sv -----
`timescale 1ns / 1ps

module rsc_rotor_cell import rsc_pkg::*; #(
  parameter int unsigned INDEX = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,       // whole chain moves on
  input  item_t in_item,
  output item_t out_item
);

  // Substitution table and this rotor's counter digit
  logic [BYTE_W-1:0] mem [TABLE_DEPTH];
  logic [BYTE_W-1:0] digit;
  logic [BYTE_W-1:0] rd_q;
  logic [BYTE_W-1:0] addr;
  item_t             q;
  item_t             q_next;
  logic              is_load;
  logic              is_enc;
  logic              sel_hit;

  assign is_load = in_item.valid && (in_item.kind == KIND_LOAD);
  assign is_enc  = in_item.valid && (in_item.kind == KIND_ENCIPHER);
  assign sel_hit = (32'(in_item.table_select) == INDEX);
  // Rotated lookup address
  assign addr    = in_item.data - digit;

  // Item handed on, with the carry into the next rotor
  always_comb begin
    q_next       = in_item;
    q_next.carry = in_item.carry && (digit == {BYTE_W{1'b1}});
  end

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (adv) begin
      if (is_load && sel_hit) begin
        mem[in_item.entry_index] <= in_item.data;
      end
      rd_q <= mem[addr];
    end
  end

  // Digit step, restart clear and stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
      digit   <= '0;
    end else if (adv) begin
      q <= q_next;
      if (in_item.valid && in_item.kind == KIND_RESTART) begin
        digit <= '0;
      end else if (is_enc && in_item.carry) begin
        digit <= digit + 1'b1;
      end
    end
  end

  // Encipher items carry the looked-up byte onward
  always_comb begin
    out_item = q;
    if (q.kind == KIND_ENCIPHER) begin
      out_item.data = rd_q;
    end
  end

endmodule
